// File: hw/rtl/lave_pkg.sv
// ----------------------------------------------------------------------------
// lave_pkg
// Shared types, codes and helper functions of the line/arrow vertex expander.
// ----------------------------------------------------------------------------
package lave_pkg;

	// input command codes
	localparam logic [1:0] CMD_LINE  = 2'd0;
	localparam logic [1:0] CMD_ARROW = 2'd1;
	localparam logic [1:0] CMD_POINT = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// output vertex kinds
	localparam logic [1:0] KIND_LINE  = 2'd0;
	localparam logic [1:0] KIND_TRI   = 2'd1;
	localparam logic [1:0] KIND_POINT = 2'd2;

	// lines at or below one pixel (Q8.4) are drawn as plain lines
	localparam logic [11:0] THIN_LIMIT = 12'd16;

	typedef enum logic [1:0] {
		CLS_POINT,
		CLS_THIN,
		CLS_THICK,
		CLS_ARROW
	} cls_t;

	// classified command held in the front queue
	typedef struct packed {
		cls_t               cls;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
		logic [11:0]        w;
		logic [31:0]        rgba;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [31:0]        rgba;
		logic [11:0]        size;
		logic               last;
	} vertex_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SQRT,
		ST_DSTART,
		ST_DWAIT,
		ST_EMIT
	} bstate_t;

	// vertex recipe: base point plus or minus a derived vector
	typedef enum logic [1:0] {
		PB_S,
		PB_E,
		PB_B
	} pbase_t;

	typedef enum logic [1:0] {
		VV_NONE,
		VV_O,
		VV_H
	} vsel_t;

	typedef struct packed {
		pbase_t pb;
		vsel_t  vv;
		logic   neg;
		logic   last;
	} vstep_t;

	// recipe of vertex idx for a command class
	function automatic vstep_t vstep(cls_t c, logic [3:0] idx);
		vstep_t s;
		s = '{pb: PB_S, vv: VV_NONE, neg: 1'b0, last: 1'b1};
		unique case (c)
			CLS_POINT: begin
				s = '{pb: PB_S, vv: VV_NONE, neg: 1'b0, last: 1'b1};
			end
			CLS_THIN: begin
				if (idx == 4'd0)
					s = '{pb: PB_S, vv: VV_NONE, neg: 1'b0, last: 1'b0};
				else
					s = '{pb: PB_E, vv: VV_NONE, neg: 1'b0, last: 1'b1};
			end
			CLS_THICK: begin
				case (idx)
					4'd0:    s = '{pb: PB_S, vv: VV_O, neg: 1'b0, last: 1'b0};
					4'd1:    s = '{pb: PB_E, vv: VV_O, neg: 1'b0, last: 1'b0};
					4'd2:    s = '{pb: PB_S, vv: VV_O, neg: 1'b1, last: 1'b0};
					4'd3:    s = '{pb: PB_E, vv: VV_O, neg: 1'b0, last: 1'b0};
					4'd4:    s = '{pb: PB_E, vv: VV_O, neg: 1'b1, last: 1'b0};
					default: s = '{pb: PB_S, vv: VV_O, neg: 1'b1, last: 1'b1};
				endcase
			end
			CLS_ARROW: begin
				case (idx)
					4'd0:    s = '{pb: PB_E, vv: VV_NONE, neg: 1'b0, last: 1'b0};
					4'd1:    s = '{pb: PB_B, vv: VV_H, neg: 1'b1, last: 1'b0};
					4'd2:    s = '{pb: PB_B, vv: VV_H, neg: 1'b0, last: 1'b0};
					4'd3:    s = '{pb: PB_S, vv: VV_O, neg: 1'b0, last: 1'b0};
					4'd4:    s = '{pb: PB_S, vv: VV_O, neg: 1'b1, last: 1'b0};
					4'd5:    s = '{pb: PB_B, vv: VV_O, neg: 1'b0, last: 1'b0};
					4'd6:    s = '{pb: PB_S, vv: VV_O, neg: 1'b1, last: 1'b0};
					4'd7:    s = '{pb: PB_B, vv: VV_O, neg: 1'b1, last: 1'b0};
					default: s = '{pb: PB_B, vv: VV_O, neg: 1'b0, last: 1'b1};
				endcase
			end
			default: s = '{pb: PB_S, vv: VV_NONE, neg: 1'b0, last: 1'b1};
		endcase
		return s;
	endfunction

	// clamp to signed 16 bits
	function automatic logic signed [15:0] sat16(logic signed [18:0] v);
		logic signed [15:0] r;
		if (v > 19'sd32767)
			r = 16'sh7fff;
		else if (v < -19'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

// File: hw/rtl/lave_front.sv
// ----------------------------------------------------------------------------
// lave_front
// Input side: accepts commands, classifies them and queues them (two deep).
// ----------------------------------------------------------------------------
module lave_front import lave_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         command,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [11:0]        width_or_size,
	input  logic [31:0]        rgba,
	output logic               head_valid,
	output cmd_t               head,
	input  logic               take
);

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       beat;
	logic       wr;
	cmd_t       cmd_in;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rptr_q];
	assign beat       = push && !full;
	// drop the unused command code at the door
	assign wr         = beat && (command != CMD_NONE);

	// classify
	always_comb begin
		cmd_in.sx   = start_x;
		cmd_in.sy   = start_y;
		cmd_in.ex   = end_x;
		cmd_in.ey   = end_y;
		cmd_in.w    = width_or_size;
		cmd_in.rgba = rgba;
		if (command == CMD_POINT)
			cmd_in.cls = CLS_POINT;
		else if (command == CMD_ARROW)
			cmd_in.cls = CLS_ARROW;
		else if (width_or_size <= THIN_LIMIT)
			cmd_in.cls = CLS_THIN;
		else
			cmd_in.cls = CLS_THICK;
	end

	// store entry
	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= cmd_in;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr)
				wptr_q <= ~wptr_q;
			if (take)
				rptr_q <= ~rptr_q;
			if (wr && !take)
				cnt_q <= cnt_q + 2'd1;
			else if (!wr && take)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: hw/rtl/lave_div.sv
// ----------------------------------------------------------------------------
// lave_div
// Restoring divider lane: sign * round(mag / den), ties away from zero,
// one quotient bit per cycle, zero for a zero divisor.
// ----------------------------------------------------------------------------
module lave_div import lave_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [39:0]        mag,
	input  logic               neg,
	input  logic [24:0]        den,
	output logic               busy,
	output logic signed [15:0] res
);

	logic [41:0] rem_q;
	logic [25:0] d_q;
	logic [3:0]  k_q;
	logic [15:0] quo_q;
	logic        neg_q;
	logic        zero_q;
	logic        busy_q;
	logic [41:0] sh;
	logic [15:0] nquo;

	assign busy = busy_q;
	assign sh   = 42'(d_q) << k_q;
	assign nquo = -quo_q;
	assign res  = zero_q ? 16'sd0 : (neg_q ? nquo : quo_q);

	// hold operands and shift out quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= 42'({mag, 1'b0}) + 42'(den);
			d_q    <= {den, 1'b0};
			quo_q  <= '0;
			neg_q  <= neg;
			zero_q <= (den == '0);
		end else if (busy_q) begin
			if (rem_q >= sh) begin
				rem_q      <= rem_q - sh;
				quo_q[k_q] <= 1'b1;
			end
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= 4'd15;
		end else if (busy_q) begin
			k_q <= k_q - 4'd1;
			if (k_q == 4'd0)
				busy_q <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/lave_back.sv
// ----------------------------------------------------------------------------
// lave_back
// Back end: takes a classified command, derives length (bit-serial square
// root) and offsets (two divider lanes) if thick/arrow, then emits vertices.
// ----------------------------------------------------------------------------
module lave_back import lave_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  cmd_t    head,
	output logic    take,
	output vertex_t vtx,
	output logic    vtx_push,
	input  logic    vtx_full
);

	localparam logic [1:0] PAIR_O = 2'd0;
	localparam logic [1:0] PAIR_A = 2'd1;
	localparam logic [1:0] PAIR_H = 2'd2;

	bstate_t            state_q, state_d;
	cmd_t               c_q;
	logic signed [16:0] dx_q, dy_q;
	logic [27:0]        pdx_q, pdy_q;
	logic [49:0]        srem_q, res_q, bit_q;
	logic [1:0]         pair_q;
	logic [3:0]         vidx_q;
	logic signed [15:0] ox_q, oy_q, ax_q, ay_q, hx_q, hy_q;

	logic               div_start;
	logic               busy_x, busy_y;
	logic signed [15:0] qx, qy;
	logic [39:0]        mag_x, mag_y;
	logic               neg_x, neg_y;

	logic [16:0]        ndx, ndy;
	logic [15:0]        adx, ady;
	logic [31:0]        sqx, sqy;
	logic [32:0]        sqsum;
	logic [29:0]        p3x, p3y;
	logic [49:0]        trial;
	logic               emit_fire, last_fire;
	vstep_t             stp;
	logic signed [17:0] bx, by, basex, basey;
	logic signed [15:0] vx, vy;
	logic signed [16:0] svx, svy;
	logic signed [18:0] sumx, sumy;

	// magnitudes and products
	assign ndx   = -dx_q;
	assign ndy   = -dy_q;
	assign adx   = dx_q[16] ? ndx[15:0] : dx_q[15:0];
	assign ady   = dy_q[16] ? ndy[15:0] : dy_q[15:0];
	assign sqx   = adx * adx;
	assign sqy   = ady * ady;
	assign sqsum = {1'b0, sqx} + {1'b0, sqy};
	assign p3x   = {2'b0, pdx_q} + {1'b0, pdx_q, 1'b0};
	assign p3y   = {2'b0, pdy_q} + {1'b0, pdy_q, 1'b0};
	assign trial = res_q + bit_q;

	// divider operands per vector pair
	always_comb begin
		unique case (pair_q)
			PAIR_A: begin
				mag_x = 40'({p3x, 9'b0});
				neg_x = dx_q[16];
				mag_y = 40'({p3y, 9'b0});
				neg_y = dy_q[16];
			end
			PAIR_H: begin
				mag_x = 40'({p3y, 8'b0});
				neg_x = ~dy_q[16];
				mag_y = 40'({p3x, 8'b0});
				neg_y = dx_q[16];
			end
			default: begin
				mag_x = 40'({pdy_q, 7'b0});
				neg_x = ~dy_q[16];
				mag_y = 40'({pdx_q, 7'b0});
				neg_y = dx_q[16];
			end
		endcase
	end

	lave_div u_div_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.mag   (mag_x),
		.neg   (neg_x),
		.den   (res_q[24:0]),
		.busy  (busy_x),
		.res   (qx)
	);

	lave_div u_div_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.mag   (mag_y),
		.neg   (neg_y),
		.den   (res_q[24:0]),
		.busy  (busy_y),
		.res   (qy)
	);

	// build the current vertex
	always_comb begin
		stp = vstep(c_q.cls, vidx_q);
		bx  = 18'(c_q.ex) - 18'(ax_q);
		by  = 18'(c_q.ey) - 18'(ay_q);
		unique case (stp.pb)
			PB_E: begin
				basex = 18'(c_q.ex);
				basey = 18'(c_q.ey);
			end
			PB_B: begin
				basex = bx;
				basey = by;
			end
			default: begin
				basex = 18'(c_q.sx);
				basey = 18'(c_q.sy);
			end
		endcase
		unique case (stp.vv)
			VV_O: begin
				vx = ox_q;
				vy = oy_q;
			end
			VV_H: begin
				vx = hx_q;
				vy = hy_q;
			end
			default: begin
				vx = 16'sd0;
				vy = 16'sd0;
			end
		endcase
		svx  = stp.neg ? -17'(vx) : 17'(vx);
		svy  = stp.neg ? -17'(vy) : 17'(vy);
		sumx = 19'(basex) + 19'(svx);
		sumy = 19'(basey) + 19'(svy);
		vtx.x    = sat16(sumx);
		vtx.y    = sat16(sumy);
		vtx.rgba = c_q.rgba;
		vtx.last = stp.last;
		vtx.size = (c_q.cls == CLS_POINT) ? c_q.w : 12'd0;
		unique case (c_q.cls)
			CLS_POINT: vtx.kind = KIND_POINT;
			CLS_THIN:  vtx.kind = KIND_LINE;
			default:   vtx.kind = KIND_TRI;
		endcase
	end

	// drive handshakes
	always_comb begin
		emit_fire = (state_q == ST_EMIT) && !vtx_full;
		last_fire = emit_fire && stp.last;
		vtx_push  = emit_fire;
		take      = head_valid && ((state_q == ST_IDLE) || last_fire);
		div_start = (state_q == ST_DSTART);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_EMIT: begin
				if (take)
					state_d = (head.cls == CLS_POINT || head.cls == CLS_THIN) ?
						ST_EMIT : ST_MUL;
				else if (last_fire)
					state_d = ST_IDLE;
			end
			ST_MUL:    state_d = ST_SQRT;
			ST_SQRT:   state_d = bit_q[0] ? ST_DSTART : ST_SQRT;
			ST_DSTART: state_d = ST_DWAIT;
			ST_DWAIT: begin
				if (!busy_x && !busy_y)
					state_d = (c_q.cls == CLS_THICK || pair_q == PAIR_H) ?
						ST_EMIT : ST_DSTART;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			c_q    <= head;
			dx_q   <= 17'(head.ex) - 17'(head.sx);
			dy_q   <= 17'(head.ey) - 17'(head.sy);
			vidx_q <= '0;
			pair_q <= PAIR_O;
			ax_q   <= 16'sd0;
			ay_q   <= 16'sd0;
		end else if (emit_fire) begin
			vidx_q <= vidx_q + 4'd1;
		end
		unique case (state_q)
			ST_MUL: begin
				pdx_q  <= adx * c_q.w;
				pdy_q  <= ady * c_q.w;
				srem_q <= {1'b0, sqsum, 16'b0};
				res_q  <= '0;
				bit_q  <= 50'd1 << 48;
			end
			ST_SQRT: begin
				if (srem_q >= trial) begin
					srem_q <= srem_q - trial;
					res_q  <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DWAIT: begin
				if (!busy_x && !busy_y) begin
					pair_q <= pair_q + 2'd1;
					unique case (pair_q)
						PAIR_A: begin
							ax_q <= qx;
							ay_q <= qy;
						end
						PAIR_H: begin
							hx_q <= qx;
							hy_q <= qy;
						end
						default: begin
							ox_q <= qx;
							oy_q <= qy;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/lave_outq.sv
// ----------------------------------------------------------------------------
// lave_outq
// Result queue, two deep, between the vertex emitter and the result ports.
// ----------------------------------------------------------------------------
module lave_outq import lave_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  vertex_t din,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output vertex_t dout
);

	vertex_t    mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rptr_q];
	assign rd    = pop && !empty;

	// store vertex
	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= din;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr)
				wptr_q <= ~wptr_q;
			if (rd)
				rptr_q <= ~rptr_q;
			if (wr && !rd)
				cnt_q <= cnt_q + 2'd1;
			else if (!wr && rd)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: hw/rtl/line_arrow_vertex_expander.sv
// ----------------------------------------------------------------------------
// line_arrow_vertex_expander
// Expands line, arrow and point draw commands into vertices in index order.
//
//   channel   handshake        beat moves
//   input     push / full      one draw command
//   result    pop / empty      one vertex
//
// Points and thin lines go straight to vertex emission. Thick lines and
// arrows first run a 25-step square root of the segment length, then one
// pass of the two divider lanes per vector pair (start, 16 quotient bits,
// collect; one pair for lines, three for arrows), then one vertex per
// cycle while the result queue has room.
// Reset clears both queues and the sequencer. A full result queue stalls
// the emitter; commands keep queuing in front until that queue fills.
// ----------------------------------------------------------------------------
module line_arrow_vertex_expander import lave_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         command,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic [11:0]        width_or_size,
	input  logic [31:0]        rgba,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         vertex_kind,
	output logic signed [15:0] vert_x,
	output logic signed [15:0] vert_y,
	output logic [31:0]        vert_rgba,
	output logic [11:0]        vert_size,
	output logic               last_vertex
);

	logic    head_valid;
	cmd_t    head;
	logic    take;
	vertex_t vtx;
	logic    vtx_push;
	logic    vtx_full;
	vertex_t vout;

	lave_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.width_or_size(width_or_size),
		.rgba         (rgba),
		.head_valid   (head_valid),
		.head         (head),
		.take         (take)
	);

	lave_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.take      (take),
		.vtx       (vtx),
		.vtx_push  (vtx_push),
		.vtx_full  (vtx_full)
	);

	lave_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (vtx_push),
		.din   (vtx),
		.full  (vtx_full),
		.pop   (pop),
		.empty (empty),
		.dout  (vout)
	);

	assign vertex_kind = vout.kind;
	assign vert_x      = vout.x;
	assign vert_y      = vout.y;
	assign vert_rgba   = vout.rgba;
	assign vert_size   = vout.size;
	assign last_vertex = vout.last;

endmodule

// File: verif/line_arrow_vertex_expander_tb.sv
// ----------------------------------------------------------------------------
// line_arrow_vertex_expander_tb
// Drives draw commands through the push/full side, predicts the vertex
// stream of each command in fixed point and checks every popped vertex
// field by field against the oldest predicted vertex.
// ----------------------------------------------------------------------------
module line_arrow_vertex_expander_tb import lave_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [1:0]         command;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic [11:0]        width_or_size;
	logic [31:0]        rgba;
	logic               empty;
	logic               pop;
	logic [1:0]         vertex_kind;
	logic signed [15:0] vert_x;
	logic signed [15:0] vert_y;
	logic [31:0]        vert_rgba;
	logic [11:0]        vert_size;
	logic               last_vertex;

	vertex_t pending_vertices[$];
	int      error_count;

	line_arrow_vertex_expander DUT (.*);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// integer square root, bit by bit
	function automatic longint unsigned root64(longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// round to nearest, ties away from zero; zero length gives zero
	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned mag, q;
		if (den == 0) return 0;
		mag = num < 0 ? longint'(-num) : num;
		q = (2 * mag + den) / (2 * den);
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic void add_vertex(logic [1:0] kind, longint x, longint y,
			logic [31:0] color, logic [11:0] size, logic fin);
		vertex_t v;
		v.kind = kind;
		v.x = clamp16(x);
		v.y = clamp16(y);
		v.rgba = color;
		v.size = size;
		v.last = fin;
		pending_vertices.push_back(v);
	endfunction

	// predict the vertices of one draw command
	function automatic void expand_command(logic [1:0] cmd, logic signed [15:0] psx,
			logic signed [15:0] psy, logic signed [15:0] pex, logic signed [15:0] pey,
			logic [11:0] pw, logic [31:0] color);
		longint sx, sy, ex, ey, w, dx, dy, ox, oy, bx, by, hx, hy;
		longint unsigned len;
		sx = psx; sy = psy; ex = pex; ey = pey; w = pw;
		dx = ex - sx;
		dy = ey - sy;
		if (cmd == CMD_POINT) begin
			add_vertex(KIND_POINT, sx, sy, color, pw, 1'b1);
			return;
		end
		if (cmd == CMD_NONE) return;
		if (cmd == CMD_LINE && pw <= THIN_LIMIT) begin
			add_vertex(KIND_LINE, sx, sy, color, 0, 1'b0);
			add_vertex(KIND_LINE, ex, ey, color, 0, 1'b1);
			return;
		end
		len = root64(longint'(dx * dx + dy * dy) << 16);
		ox = round_div(-dy * w * 128, len);
		oy = round_div(dx * w * 128, len);
		if (cmd == CMD_LINE) begin
			add_vertex(KIND_TRI, sx + ox, sy + oy, color, 0, 1'b0);
			add_vertex(KIND_TRI, ex + ox, ey + oy, color, 0, 1'b0);
			add_vertex(KIND_TRI, sx - ox, sy - oy, color, 0, 1'b0);
			add_vertex(KIND_TRI, ex + ox, ey + oy, color, 0, 1'b0);
			add_vertex(KIND_TRI, ex - ox, ey - oy, color, 0, 1'b0);
			add_vertex(KIND_TRI, sx - ox, sy - oy, color, 0, 1'b1);
		end else begin
			bx = ex - round_div(dx * w * 1536, len);
			by = ey - round_div(dy * w * 1536, len);
			hx = round_div(-dy * w * 768, len);
			hy = round_div(dx * w * 768, len);
			add_vertex(KIND_TRI, ex, ey, color, 0, 1'b0);
			add_vertex(KIND_TRI, bx - hx, by - hy, color, 0, 1'b0);
			add_vertex(KIND_TRI, bx + hx, by + hy, color, 0, 1'b0);
			add_vertex(KIND_TRI, sx + ox, sy + oy, color, 0, 1'b0);
			add_vertex(KIND_TRI, sx - ox, sy - oy, color, 0, 1'b0);
			add_vertex(KIND_TRI, bx + ox, by + oy, color, 0, 1'b0);
			add_vertex(KIND_TRI, sx - ox, sy - oy, color, 0, 1'b0);
			add_vertex(KIND_TRI, bx - ox, by - oy, color, 0, 1'b0);
			add_vertex(KIND_TRI, bx + ox, by + oy, color, 0, 1'b1);
		end
	endfunction

	// send one command beat after a random gap; predict on acceptance
	task automatic send_command(logic [1:0] cmd, logic [15:0] sx, logic [15:0] sy,
			logic [15:0] ex, logic [15:0] ey, logic [11:0] w, logic [31:0] color);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		width_or_size <= w;
		rgba <= color;
		do @(posedge clk); while (full);
		expand_command(cmd, sx, sy, ex, ey, w, color);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 16'h8000 + 16'($urandom_range(0, 3));
			1: return 16'h7fff - 16'($urandom_range(0, 3));
			2: return 16'($urandom_range(0, 2047)) - 16'd1024;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [11:0] rand_width();
		case ($urandom_range(0, 3))
			0: return 12'($urandom_range(0, 17));
			1: return 12'hfff - 12'($urandom_range(0, 2));
			default: return 12'($urandom);
		endcase
	endfunction

	task automatic test_directed_extremes();
		send_command(CMD_POINT, 16'h8000, 16'h7fff, 0, 0, 12'hfff, 32'hffffffff);
		send_command(CMD_POINT, 16'h7fff, 16'h8000, 16'hffff, 16'hffff, 0, 0);
		send_command(CMD_LINE, 0, 0, 16'd160, 16'd80, 12'd16, 32'h12345678);
		send_command(CMD_LINE, 0, 0, 16'd160, 16'd80, 12'd17, 32'h9abcdef0);
		send_command(CMD_LINE, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 12'hfff, 32'h1);
		send_command(CMD_LINE, 16'h7fff, 0, 16'h8000, 0, 12'hfff, 32'h2);
		send_command(CMD_ARROW, 0, 0, 16'd1600, 16'd0, 12'd32, 32'h3);
		send_command(CMD_ARROW, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 12'hfff, 32'h4);
		// zero-length segment: offsets collapse
		send_command(CMD_LINE, 16'd50, 16'd60, 16'd50, 16'd60, 12'd100, 32'h5);
		send_command(CMD_ARROW, 16'd50, 16'd60, 16'd50, 16'd60, 12'd100, 32'h6);
		// zero thickness arrow still gives nine vertices
		send_command(CMD_ARROW, 0, 0, 16'd300, 16'd400, 12'd0, 32'h7);
		// unused command code gives nothing
		send_command(CMD_NONE, 16'd1, 16'd2, 16'd3, 16'd4, 12'd5, 32'h8);
		send_command(CMD_LINE, 16'd10, 16'd10, 16'd10, 16'd200, 12'd48, 32'h9);
	endtask

	task automatic test_random_commands();
		logic [1:0] cmd;
		logic [15:0] sx, sy;
		for (int i = 0; i < 360; i++) begin
			cmd = $urandom_range(0, 9) == 0 ? CMD_NONE : 2'($urandom_range(0, 2));
			sx = rand_coord();
			sy = rand_coord();
			if ($urandom_range(0, 1))
				send_command(cmd, sx, sy, sx + 16'($urandom_range(0, 400)) - 16'd200,
					sy + 16'($urandom_range(0, 400)) - 16'd200, rand_width(), $urandom);
			else
				send_command(cmd, sx, sy, rand_coord(), rand_coord(), rand_width(), $urandom);
		end
	endtask

	// pop with random stalls and compare against the oldest prediction
	initial begin
		int stall;
		vertex_t exp_v;
		pop = 1'b0;
		error_count = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (pending_vertices.size() == 0) begin
				$display("%0t: unexpected vertex x=%0d y=%0d", $time, vert_x, vert_y);
				error_count++;
			end else begin
				exp_v = pending_vertices.pop_front();
				if (vertex_kind !== exp_v.kind || vert_x !== exp_v.x || vert_y !== exp_v.y
						|| vert_rgba !== exp_v.rgba || vert_size !== exp_v.size
						|| last_vertex !== exp_v.last) begin
					$display("%0t: expected k=%0d x=%0d y=%0d c=%h s=%0d l=%0b", $time,
						exp_v.kind, exp_v.x, exp_v.y, exp_v.rgba, exp_v.size, exp_v.last);
					$display("%0t: actual   k=%0d x=%0d y=%0d c=%h s=%0d l=%0b", $time,
						vertex_kind, vert_x, vert_y, vert_rgba, vert_size, last_vertex);
					error_count++;
				end
			end
		end
	end

	initial begin
		push = 1'b0;
		command = CMD_LINE;
		start_x = 0;
		start_y = 0;
		end_x = 0;
		end_y = 0;
		width_or_size = 0;
		rgba = 0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_directed_extremes();
		test_random_commands();
		push <= 1'b0;
		wait (pending_vertices.size() == 0);
		repeat (200) @(negedge clk);
		if (error_count == 0 && pending_vertices.size() == 0)
			$display("line_arrow_vertex_expander verification clean");
		else
			$display("line_arrow_vertex_expander verification failed");
		$finish;
	end

	// timeout
	initial begin
		#20ms;
		$display("line_arrow_vertex_expander verification failed");
		$finish;
	end

endmodule
